@@ sv/dfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfb_pkg: shared types and constants of the descriptor fifo
// widths, codes and the descriptor struct used by the cells and the top level
// ----------------------------------------------------------------------------
package dfb_pkg;

   // default number of cells; the 5-bit capacity register limits use to 31
   localparam int DFB_DEPTH = 16;

   localparam int WORD_W  = 32;
   localparam int CNT_W   = 5;
   localparam int STAT_W  = 2;
   localparam int REGID_W = 8;

   // operations
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BUDGET = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

   // register indexes
   localparam logic [REGID_W-1:0] REG_CAPACITY = 8'd0;
   localparam logic [REGID_W-1:0] REG_BUDGET   = 8'd1;

   typedef struct packed {
      logic [WORD_W-1:0] handle;
      logic [WORD_W-1:0] size;
      logic [WORD_W-1:0] tag;
   } desc_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      desc_type          desc;
      logic [CNT_W-1:0]  entry_count;
      logic [CNT_W-1:0]  free_slots;
      logic              empty_flag;
      logic              full_flag;
      logic [WORD_W-1:0] bytes_in_use;
   } rsp_type;

endpackage

@@ sv/dfb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfb_if: channel interfaces of the descriptor fifo
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface dfb_req_if
   import dfb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [WORD_W-1:0] item_handle;
   logic [WORD_W-1:0] item_size;
   logic [WORD_W-1:0] item_type;

   modport source (output valid, operation, item_handle, item_size, item_type,
                   input ready);
   modport sink   (input valid, operation, item_handle, item_size, item_type,
                   output ready);
endinterface

interface dfb_rsp_if
   import dfb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [WORD_W-1:0] out_handle;
   logic [WORD_W-1:0] out_size;
   logic [WORD_W-1:0] out_type;
   logic [CNT_W-1:0]  entry_count;
   logic [CNT_W-1:0]  free_slots;
   logic              empty_flag;
   logic              full_flag;
   logic [WORD_W-1:0] bytes_in_use;

   modport source (output valid, status, out_handle, out_size, out_type,
                   entry_count, free_slots, empty_flag, full_flag, bytes_in_use,
                   input ready);
   modport sink   (input valid, status, out_handle, out_size, out_type,
                   entry_count, free_slots, empty_flag, full_flag, bytes_in_use,
                   output ready);
endinterface

interface dfb_csr_if
   import dfb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [REGID_W-1:0] reg_index;
   logic [WORD_W-1:0]  wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ sv/dfb_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfb_cell: one descriptor slot of the shifting queue
// loads a new descriptor or takes its upstream neighbor's on a pop
// ----------------------------------------------------------------------------
module dfb_cell
   import dfb_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  desc_type     load_data,
   input  desc_type     next_data,
   output desc_type     data_out
);

   desc_type data_ff;
   desc_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

@@ sv/descriptor_fifo_with_byte_budget.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_fifo_with_byte_budget: descriptor queue with a byte limit
// push/pop queue of handle/size/tag descriptors kept in a chain of cells,
// with a slot capacity register and a budget on the summed byte sizes
// ----------------------------------------------------------------------------
//
//  channel   dir  modport  beat contents
//  req_bus   in   sink     operation, item_handle, item_size, item_type
//  rsp_bus   out  source   status, descriptor, count, free, flags, bytes
//  csr_bus   in   sink     reg_index (0 capacity, 1 byte budget), wr_data
//
//  one request beat per cycle while req_ready is high; each beat gives its
//  response beat in the cycle after acceptance, from the response register
//  the cycle is set by the 33-bit budget add and compare on a push
//  req_ready drops only while a response waits and rsp_ready is low
//  reset (synchronous, active high) empties the queue, capacity goes to the
//  cell count and the budget to zero; register writes are always taken
//
module descriptor_fifo_with_byte_budget
   import dfb_pkg::*;
#(
   parameter int DEPTH = DFB_DEPTH
)(
   input  logic   clock,
   input  logic   reset,
   dfb_req_if.sink   req_bus,
   dfb_rsp_if.source rsp_bus,
   dfb_csr_if.sink   csr_bus
);

   // cells actually built; capacity is a 5-bit register
   localparam int NCELL = (DEPTH < 31) ? DEPTH : 31;

   // control state
   logic [CNT_W-1:0]  cap_ff, cap_in;       // effective capacity, 1..NCELL
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] total_ff, total_in;
   logic [WORD_W-1:0] budget_ff, budget_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // datapath
   desc_type          cell_q   [NCELL];
   cell_ctl_type      cell_ctl [NCELL];
   desc_type          req_desc;
   desc_type          front;

   logic              req_acc, csr_acc;
   logic              push, pop, push_ok, pop_ok;
   logic              is_full, is_empty, over;
   logic [WORD_W:0]   sum, limit;
   logic [CNT_W-1:0]  wr_cap;

   assign req_desc = '{handle: req_bus.item_handle, size: req_bus.item_size,
                       tag: req_bus.item_type};
   assign front    = cell_q[0];

   // handshakes
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_acc       = csr_bus.valid;

   // capacity clamp: zero acts as one, above the cell count acts as the count
   always_comb begin
      wr_cap = csr_bus.wr_data[CNT_W-1:0];
      if (wr_cap == '0) begin
         wr_cap = CNT_W'(1);
      end else if (wr_cap > CNT_W'(NCELL)) begin
         wr_cap = CNT_W'(NCELL);
      end
   end

   // push/pop decisions
   assign push     = req_acc && (req_bus.operation == OP_PUSH);
   assign pop      = req_acc && (req_bus.operation == OP_POP);
   assign is_full  = (count_ff == cap_ff);
   assign is_empty = (count_ff == '0);
   assign sum      = {1'b0, total_ff} + {1'b0, req_bus.item_size};
   assign limit    = (budget_ff != '0) ? {1'b0, budget_ff} : {1'b0, {WORD_W{1'b1}}};
   assign over     = (sum > limit);
   assign push_ok  = push && !is_full && !over;
   assign pop_ok   = pop && !is_empty;

   // next state and response
   always_comb begin
      cap_in       = cap_ff;
      budget_in    = budget_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
         total_in = sum[WORD_W-1:0];
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
         // clamp at zero on the way down
         total_in = (total_ff >= front.size) ? (total_ff - front.size) : '0;
      end

      if (req_acc) begin
         rsp_valid_in        = 1'b1;
         rsp_in.entry_count  = count_in;
         rsp_in.free_slots   = cap_ff - count_in;
         rsp_in.empty_flag   = (count_in == '0);
         rsp_in.full_flag    = (count_in == cap_ff);
         rsp_in.bytes_in_use = total_in;
         rsp_in.desc         = '0;
         if (pop) begin
            rsp_in.status = pop_ok ? ST_OK : ST_EMPTY;
            if (pop_ok) begin
               rsp_in.desc = front;
            end
         end else begin
            if (is_full) begin
               rsp_in.status = ST_FULL;
            end else if (over) begin
               rsp_in.status = ST_BUDGET;
            end else begin
               rsp_in.status = ST_OK;
            end
            // front after the push: the new item when it lands in an empty queue
            if (push_ok && is_empty) begin
               rsp_in.desc = req_desc;
            end else if (!is_empty) begin
               rsp_in.desc = front;
            end
         end
      end

      // register writes must come only while idle; the block itself does not enforce it
      if (csr_acc) begin
         case (csr_bus.reg_index)
            REG_CAPACITY: begin
               cap_in   = wr_cap;
               count_in = '0;
               total_in = '0;
            end
            REG_BUDGET: begin
               budget_in = csr_bus.wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CNT_W'(NCELL);
         budget_ff    <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         budget_ff    <= budget_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // chain of cells: cell 0 is the front, a pop moves every cell one step
   // forward, a push loads the cell just past the last stored one
   genvar i;
   generate
      for (i = 0; i < NCELL; i++) begin : g_cell
         assign cell_ctl[i].load  = push_ok && (count_ff == CNT_W'(i));
         assign cell_ctl[i].shift = pop_ok;
         if (i == NCELL - 1) begin : g_last
            dfb_cell u_cell (
               .clock     (clock),
               .ctl       (cell_ctl[i]),
               .load_data (req_desc),
               .next_data (cell_q[i]),
               .data_out  (cell_q[i])
            );
         end else begin : g_mid
            dfb_cell u_cell (
               .clock     (clock),
               .ctl       (cell_ctl[i]),
               .load_data (req_desc),
               .next_data (cell_q[i+1]),
               .data_out  (cell_q[i])
            );
         end
      end
   endgenerate

   // response port
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_ff.status;
   assign rsp_bus.out_handle   = rsp_ff.desc.handle;
   assign rsp_bus.out_size     = rsp_ff.desc.size;
   assign rsp_bus.out_type     = rsp_ff.desc.tag;
   assign rsp_bus.entry_count  = rsp_ff.entry_count;
   assign rsp_bus.free_slots   = rsp_ff.free_slots;
   assign rsp_bus.empty_flag   = rsp_ff.empty_flag;
   assign rsp_bus.full_flag    = rsp_ff.full_flag;
   assign rsp_bus.bytes_in_use = rsp_ff.bytes_in_use;

   // checks
   a_count_le_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("entry count above capacity");

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (total_ff == '0))
      else $error("bytes in use while queue is empty");

   a_pop_empty_status: assert property (@(posedge clock) disable iff (reset)
      (pop && is_empty) |=> (rsp_valid_ff && rsp_ff.status == ST_EMPTY))
      else $error("pop on empty queue without empty status");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.empty_flag && rsp_ff.full_flag))
      else $error("empty and full flags both set");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the descriptor fifo with byte budget
// drives push/pop request beats and register writes, tracks the queue in a
// local model and checks each response beat field by field
// ----------------------------------------------------------------------------
module tb;
   import dfb_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 6;     // response comes in the cycle after accept
   localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
   localparam int RAND_PHASES  = 20;
   localparam int PHASE_BEATS  = 74;

   // fill level of the tracked queue
   typedef enum logic [1:0] {FILL_EMPTY, FILL_PARTIAL, FILL_FULL} fill_level_type;

   logic clock;
   logic reset;

   dfb_req_if req ();
   dfb_rsp_if rsp ();
   dfb_csr_if csr ();

   descriptor_fifo_with_byte_budget #(
      .DEPTH(DFB_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   // tracked queue state and registers
   desc_type       slot_mem [DFB_DEPTH];
   int unsigned    wr_ptr;
   int unsigned    rd_ptr;
   fill_level_type fill;
   logic [31:0]    bytes_held;
   logic [4:0]     cap_reg;
   logic [31:0]    budget_reg;

   // responses still owed by the block, oldest first
   rsp_type pending_rsps[$];

   int  mismatches;
   int  cycle_count;
   bit  idling;        // random gaps on both sides
   int  hold_asked;    // bumped by a test to request a receiver hold-off
   int  hold_served;
   int  stall_left;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsps.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // queue model: one push or pop, returns the response beat it causes
   // ---------------------------------------------------------------------
   function automatic rsp_type fifo_step(logic op, desc_type d);
      rsp_type     r;
      int unsigned cap;
      int unsigned cnt;
      logic [32:0] sum;
      logic [32:0] lim;
      r = '0;
      // zero capacity behaves as one slot, anything above the cells as all
      if (cap_reg == 0)
         cap = 1;
      else if (cap_reg > DFB_DEPTH)
         cap = DFB_DEPTH;
      else
         cap = 32'(cap_reg);
      if (wr_ptr >= cap) wr_ptr = 0;
      if (rd_ptr >= cap) rd_ptr = 0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
         if (fill == FILL_FULL) begin
            r.status = ST_FULL;
         end else begin
            // sum without wrap; zero budget still caps at 32 bits
            sum = {1'b0, bytes_held} + {1'b0, d.size};
            lim = (budget_reg != 0) ? {1'b0, budget_reg} : {1'b0, 32'hFFFF_FFFF};
            if (sum > lim) begin
               r.status = ST_BUDGET;
            end else begin
               slot_mem[wr_ptr] = d;
               bytes_held = sum[31:0];
               wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
               fill = (wr_ptr == rd_ptr) ? FILL_FULL : FILL_PARTIAL;
            end
         end
         // a push reports the front descriptor when the queue is not empty
         if (fill != FILL_EMPTY)
            r.desc = slot_mem[rd_ptr];
      end else begin
         if (fill == FILL_EMPTY) begin
            r.status = ST_EMPTY;
         end else begin
            r.desc = slot_mem[rd_ptr];
            bytes_held = (bytes_held >= r.desc.size) ? bytes_held - r.desc.size : 32'd0;
            rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
            fill = (wr_ptr == rd_ptr) ? FILL_EMPTY : FILL_PARTIAL;
         end
      end
      if (fill == FILL_FULL)
         cnt = cap;
      else if (fill == FILL_EMPTY)
         cnt = 0;
      else if (wr_ptr >= rd_ptr)
         cnt = wr_ptr - rd_ptr;
      else
         cnt = cap - rd_ptr + wr_ptr;
      r.entry_count  = cnt[CNT_W-1:0];
      r.free_slots   = CNT_W'(cap - cnt);
      r.empty_flag   = (fill == FILL_EMPTY);
      r.full_flag    = (fill == FILL_FULL);
      r.bytes_in_use = bytes_held;
      return r;
   endfunction

   // register write as seen by the model; capacity also empties the queue
   function automatic void apply_reg(logic [REGID_W-1:0] idx, logic [31:0] data);
      if (idx == REG_CAPACITY) begin
         cap_reg    = data[4:0];
         wr_ptr     = 0;
         rd_ptr     = 0;
         fill       = FILL_EMPTY;
         bytes_held = '0;
      end else if (idx == REG_BUDGET) begin
         budget_reg = data;
      end
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // offer one request beat, hold it until accepted, then log the response owed
   task automatic send_beat(logic op, logic [31:0] handle, logic [31:0] size,
                            logic [31:0] tag);
      desc_type d;
      d.handle = handle;
      d.size   = size;
      d.tag    = tag;
      if (idling && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.operation   <= op;
      req.item_handle <= handle;
      req.item_size   <= size;
      req.item_type   <= tag;
      do @(posedge clock); while (!req.ready);
      pending_rsps.push_back(fifo_step(op, d));
   endtask

   // write one register; only called with the block idle
   task automatic write_reg(logic [REGID_W-1:0] idx, logic [31:0] data);
      csr.valid     <= 1'b1;
      csr.reg_index <= idx;
      csr.wr_data   <= data;
      do @(posedge clock); while (!csr.ready);
      apply_reg(idx, data);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, wait for every owed response, then let the bench go quiet
   task automatic settle();
      req.valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sizes: mostly small so queues fill, with zero, all-ones and full range
   function automatic logic [31:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   task automatic send_random(int push_pct);
      logic op;
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      send_beat(op, $urandom, pick_size(), $urandom);
   endtask

   // ---------------------------------------------------------------------
   // response side: random stalls, long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      rsp.ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp.ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (hold_asked != hold_served) begin
            rsp.ready   <= 1'b0;
            hold_served <= hold_asked;
            stall_left  <= HOLD_CYCLES - 1;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            // stall for a burst of random length
            rsp.ready  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // compare each response beat with the oldest one owed
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: unexpected response beat, expected none actual status %0d",
                        $time, rsp.status);
               mismatches++;
            end else begin
               want = pending_rsps.pop_front();
               check_field("status",       32'(want.status),      32'(rsp.status));
               check_field("out_handle",   want.desc.handle,      rsp.out_handle);
               check_field("out_size",     want.desc.size,        rsp.out_size);
               check_field("out_type",     want.desc.tag,         rsp.out_type);
               check_field("entry_count",  32'(want.entry_count), 32'(rsp.entry_count));
               check_field("free_slots",   32'(want.free_slots),  32'(rsp.free_slots));
               check_field("empty_flag",   32'(want.empty_flag),  32'(rsp.empty_flag));
               check_field("full_flag",    32'(want.full_flag),   32'(rsp.full_flag));
               check_field("bytes_in_use", want.bytes_in_use,     rsp.bytes_in_use);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset settings: empty pop, extreme descriptors, overflow of the byte sum
   task automatic test_basic_ops();
      send_beat(OP_POP, $urandom, $urandom, $urandom);         // pop when empty
      send_beat(OP_PUSH, 32'd0, 32'd0, 32'd0);
      send_beat(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_PUSH, $urandom, 32'd1, $urandom);           // sum would wrap
      send_beat(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_POP, $urandom, $urandom, $urandom);
      send_beat(OP_POP, $urandom, $urandom, $urandom);         // empty again
   endtask

   // capacity out of range and the clear on a capacity write
   task automatic test_capacity_edges();
      settle();
      write_reg(REG_CAPACITY, 32'hFFFF_FFE0);   // low bits zero, one slot
      send_beat(OP_PUSH, 32'hA5A5_0001, 32'd7, 32'h0000_0011);
      send_beat(OP_PUSH, 32'hA5A5_0002, 32'd9, 32'h0000_0022);   // full
      send_beat(OP_POP, $urandom, $urandom, $urandom);
      settle();
      write_reg(REG_CAPACITY, 32'd31);          // clamps to the cell count
      send_beat(OP_PUSH, $urandom, 32'd100, $urandom);
      send_beat(OP_PUSH, $urandom, 32'd200, $urandom);
      settle();
      write_reg(REG_CAPACITY, 32'd2);           // drops the two queued items
      send_beat(OP_POP, $urandom, $urandom, $urandom);
   endtask

   // budget refusal, a push refused as full, budget lowered under stored items
   task automatic test_budget_limits();
      settle();
      write_reg(REG_BUDGET, 32'd100);
      send_beat(OP_PUSH, $urandom, 32'd60, $urandom);
      send_beat(OP_PUSH, $urandom, 32'd41, $urandom);   // 101 over budget
      send_beat(OP_PUSH, $urandom, 32'd40, $urandom);   // exactly at budget, full
      send_beat(OP_PUSH, $urandom, 32'd0, $urandom);    // refused as full
      settle();
      write_reg(REG_BUDGET, 32'd50);                    // items stay
      send_beat(OP_POP, $urandom, $urandom, $urandom);
      send_beat(OP_PUSH, $urandom, 32'd20, $urandom);   // 60 over 50
      send_beat(OP_PUSH, $urandom, 32'd10, $urandom);
      settle();
      write_reg(REG_BUDGET, 32'hFFFF_FFFF);
      write_reg(REGID_W'($urandom_range(REG_BUDGET + 1, 255)), $urandom);  // unmapped
      send_beat(OP_POP, $urandom, $urandom, $urandom);
      send_beat(OP_POP, $urandom, $urandom, $urandom);
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      settle();
      write_reg(REG_CAPACITY, 32'd16);
      write_reg(REG_BUDGET, 32'd0);
      idling     <= 1'b0;
      hold_asked <= hold_asked + 1;
      repeat (40) send_random(70);
      settle();
      idling <= 1'b1;
   endtask

   // random phases under changing settings
   task automatic test_random_mix();
      int          push_pct;
      logic [31:0] cap_val;
      logic [31:0] budget_val;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         settle();
         // quiet tail: no gaps on either side
         if (phase == RAND_PHASES - 3)
            idling <= 1'b0;
         case ($urandom_range(0, 7))
            0:       cap_val = 32'd0;
            1:       cap_val = 32'd1;
            2:       cap_val = 32'd2;
            3:       cap_val = 32'd17;
            4:       cap_val = 32'd31;
            5:       cap_val = $urandom_range(3, 15);
            6:       cap_val = $urandom;
            default: cap_val = 32'd16;
         endcase
         case ($urandom_range(0, 5))
            0:       budget_val = 32'd1;
            1:       budget_val = 32'hFFFF_FFFF;
            2:       budget_val = $urandom;
            3:       budget_val = $urandom_range(50, 600);
            default: budget_val = 32'd0;
         endcase
         push_pct = $urandom_range(30, 75);
         // every fifth phase fills the whole ring with no byte limit
         if (phase % 5 == 1) begin
            cap_val    = 32'd16;
            budget_val = 32'd0;
            push_pct   = 75;
         end
         // sometimes keep the queue and change only the budget
         if (phase == 0 || $urandom_range(0, 3) != 0)
            write_reg(REG_CAPACITY, cap_val);
         write_reg(REG_BUDGET, budget_val);
         if ($urandom_range(0, 5) == 0)
            write_reg(REGID_W'($urandom_range(REG_BUDGET + 1, 255)), $urandom);
         repeat (PHASE_BEATS) send_random(push_pct);
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      // known values on every input from time zero
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.operation   = OP_PUSH;
      req.item_handle = '0;
      req.item_size   = '0;
      req.item_type   = '0;
      csr.valid       = 1'b0;
      csr.reg_index   = REG_CAPACITY;
      csr.wr_data     = '0;
      mismatches      = 0;
      cycle_count     = 0;
      idling          = 1'b1;
      hold_asked      = 0;
      hold_served     = 0;
      // model matches the reset values
      cap_reg         = 5'(DFB_DEPTH);
      budget_reg      = '0;
      wr_ptr          = 0;
      rd_ptr          = 0;
      fill            = FILL_EMPTY;
      bytes_held      = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_capacity_edges();
      test_budget_limits();
      test_backpressure();
      test_random_mix();

      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ files.f @@
sv/dfb_pkg.sv
sv/dfb_if.sv
sv/dfb_cell.sv
sv/descriptor_fifo_with_byte_budget.sv
tb/tb.sv
